@@ rtl/core/lcp_interval_enumerator_macros.svh @@
// ============================================================================
// LCP interval enumerator assertion macros
// Shared property shorthands for the checker.
// ============================================================================
`ifndef LCP_INTERVAL_ENUMERATOR_MACROS_SVH
`define LCP_INTERVAL_ENUMERATOR_MACROS_SVH

// same-cycle implication
`define LCP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LCP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/lcp_pkg.sv @@
// ============================================================================
// LCP interval enumerator package
// Constants, stack entry type and sequencer state shared by the core.
// ============================================================================
package lcp_pkg;

   localparam int unsigned MAX_TEXT    = 65536;
   localparam int unsigned STACK_DEPTH = 64;
   localparam int unsigned CELL_COUNT  = STACK_DEPTH - 1;
   localparam int unsigned POS_W       = $clog2(MAX_TEXT + 1);
   localparam int unsigned VAL_W       = 16;

   localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_TEXT);

   typedef struct packed {
      logic             valid;
      logic [VAL_W-1:0] length;
      logic [VAL_W-1:0] left;
   } entry_type;

   typedef struct packed {
      logic push;
      logic pop;
   } cell_op_type;

   typedef enum logic {
      ST_IDLE,
      ST_WORK
   } state_type;

   localparam entry_type ENTRY_EMPTY = '{valid: 1'b0, length: '0, left: '0};

endpackage

@@ rtl/core/lcp_if.sv @@
// ============================================================================
// LCP interval enumerator channels
// Valid/ready channels for LCP words in and interval words out.
// ============================================================================
interface lcp_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] lcp_value;
   logic        end_of_array;

   modport source (output valid, output lcp_value, output end_of_array, input ready);
   modport sink   (input valid, input lcp_value, input end_of_array, output ready);
endinterface

interface lcp_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] interval_length;
   logic [15:0] left_bound;
   logic [15:0] right_bound;
   logic        last_of_run;
   logic        overflow;

   modport source (output valid, output interval_length, output left_bound,
                   output right_bound, output last_of_run, output overflow, input ready);
   modport sink   (input valid, input interval_length, input left_bound,
                   input right_bound, input last_of_run, input overflow, output ready);
endinterface

@@ rtl/core/lcp_cell.sv @@
// ============================================================================
// LCP stack cell
// One entry of the shifting stack: loads from above on push, below on pop.
// ============================================================================
module lcp_cell
   import lcp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cell_op_type op,
   input  entry_type   upper,
   input  entry_type   lower,
   output entry_type   entry
);

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (op.push) begin
         entry_in = upper;
      end else if (op.pop) begin
         entry_in = lower;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= ENTRY_EMPTY;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule

@@ rtl/core/lcp_interval_enumerator.sv @@
// Flow: an accepted word is held in the value register; each interval it
//   closes is loaded into the output registers and then shown on rsp_port.
// Throughput: one stack pop per cycle through the cell chain, while the
//   output slot is free; a new word is taken only once the last is done.
// Reset: synchronous, clears the stack valid bits, position to 1, overflow.
// ============================================================================
// LCP interval enumerator
// Bottom-up lcp-interval traversal over a shifting stack of cells.
// ============================================================================
module lcp_interval_enumerator
   import lcp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   lcp_req_if.sink   req_port,
   lcp_rsp_if.source rsp_port
);

   state_type        state_ff, state_in;
   logic [VAL_W-1:0] value_ff, value_in;
   logic             end_ff, end_in;
   logic [POS_W-1:0] position_ff, position_in;
   logic [VAL_W-1:0] lb_ff, lb_in;
   logic             ovf_ff, ovf_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0] rsp_len_ff, rsp_len_in;
   logic [VAL_W-1:0] rsp_left_ff, rsp_left_in;
   logic [VAL_W-1:0] rsp_right_ff, rsp_right_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             rsp_ovf_ff, rsp_ovf_in;

   entry_type        cells [CELL_COUNT];
   entry_type        up_data [CELL_COUNT];
   entry_type        dn_data [CELL_COUNT];
   entry_type        new_entry;
   cell_op_type      op;

   logic [VAL_W-1:0] top_len;
   logic [VAL_W-1:0] pos_m1;
   logic             pop_hit;
   logic             next_hit;
   logic             slot_free;

   genvar i;
   generate
      for (i = 0; i < CELL_COUNT; i++) begin : g_cell
         if (i == 0) begin : g_first
            assign up_data[i] = new_entry;
         end else begin : g_up
            assign up_data[i] = cells[i-1];
         end
         if (i == CELL_COUNT - 1) begin : g_last
            assign dn_data[i] = ENTRY_EMPTY;
         end else begin : g_dn
            assign dn_data[i] = cells[i+1];
         end
         lcp_cell u_cell (
            .clock (clock),
            .reset (reset),
            .op    (op),
            .upper (up_data[i]),
            .lower (dn_data[i]),
            .entry (cells[i])
         );
      end
   endgenerate

   assign top_len   = cells[0].valid ? cells[0].length : '0;
   assign pos_m1    = VAL_W'(position_ff - POS_W'(1));
   assign pop_hit   = cells[0].valid && (value_ff < cells[0].length);
   assign next_hit  = cells[1].valid && (value_ff < cells[1].length);
   assign slot_free = !rsp_valid_ff || rsp_port.ready;
   assign new_entry = '{valid: 1'b1, length: value_ff, left: lb_ff};

   always_comb begin
      state_in     = state_ff;
      value_in     = value_ff;
      end_in       = end_ff;
      position_in  = position_ff;
      lb_in        = lb_ff;
      ovf_in       = ovf_ff;
      op           = '{push: 1'b0, pop: 1'b0};
      req_port.ready = 1'b0;

      rsp_valid_in = rsp_valid_ff && !rsp_port.ready;
      rsp_len_in   = rsp_len_ff;
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      case (state_ff)
         ST_IDLE: begin
            req_port.ready = 1'b1;
            if (req_port.valid) begin
               value_in = req_port.end_of_array ? '0 : req_port.lcp_value;
               end_in   = req_port.end_of_array;
               lb_in    = pos_m1;
               state_in = ST_WORK;
            end
         end
         ST_WORK: begin
            if (pop_hit) begin
               if (slot_free) begin
                  op.pop       = 1'b1;
                  lb_in        = cells[0].left;
                  rsp_valid_in = 1'b1;
                  rsp_len_in   = cells[0].length;
                  rsp_left_in  = cells[0].left;
                  rsp_right_in = pos_m1;
                  rsp_last_in  = !next_hit;
                  rsp_ovf_in   = ovf_ff;
               end
            end else begin
               state_in = ST_IDLE;
               if (end_ff) begin
                  position_in = POS_W'(1);
               end else begin
                  if (value_ff > top_len) begin
                     if (cells[CELL_COUNT-1].valid) begin
                        ovf_in = 1'b1;
                     end else begin
                        op.push = 1'b1;
                     end
                  end
                  if (position_ff < MAX_POS) begin
                     position_in = position_ff + POS_W'(1);
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         position_ff  <= POS_W'(1);
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         position_ff  <= position_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff     <= value_in;
      end_ff       <= end_in;
      lb_ff        <= lb_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_port.valid           = rsp_valid_ff;
   assign rsp_port.interval_length = rsp_len_ff;
   assign rsp_port.left_bound      = rsp_left_ff;
   assign rsp_port.right_bound     = rsp_right_ff;
   assign rsp_port.last_of_run     = rsp_last_ff;
   assign rsp_port.overflow        = rsp_ovf_ff;

endmodule

@@ rtl/core/lcp_checker.sv @@
// ============================================================================
// LCP interval enumerator checker
// Port-level properties of the interval word stream, bound to the top level.
// ============================================================================
`include "lcp_interval_enumerator_macros.svh"

module lcp_checker
   import lcp_pkg::*;
(
   input logic       clock,
   input logic       reset,
   lcp_rsp_if.source rsp_port
);

   logic             rsp_take;
   logic             run_ff, run_in;
   logic             ovf_seen_ff, ovf_seen_in;
   logic [VAL_W-1:0] prev_len_ff, prev_len_in;
   logic [VAL_W-1:0] prev_rb_ff, prev_rb_in;

   assign rsp_take = rsp_port.valid && rsp_port.ready;

   always_comb begin
      run_in      = run_ff;
      ovf_seen_in = ovf_seen_ff;
      prev_len_in = prev_len_ff;
      prev_rb_in  = prev_rb_ff;
      if (rsp_take) begin
         run_in      = !rsp_port.last_of_run;
         ovf_seen_in = ovf_seen_ff || rsp_port.overflow;
         prev_len_in = rsp_port.interval_length;
         prev_rb_in  = rsp_port.right_bound;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff      <= 1'b0;
         ovf_seen_ff <= 1'b0;
      end else begin
         run_ff      <= run_in;
         ovf_seen_ff <= ovf_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_len_ff <= prev_len_in;
      prev_rb_ff  <= prev_rb_in;
   end

   `LCP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_port.valid && !rsp_port.ready, rsp_port.valid && $stable(rsp_port.interval_length) && $stable(rsp_port.right_bound), "rsp word changed while stalled")
   `LCP_ASSERT_IMPLY(a_ovf_sticky, clock, reset, rsp_port.valid && ovf_seen_ff, rsp_port.overflow, "overflow flag dropped")
   `LCP_ASSERT_IMPLY(a_run_order, clock, reset, rsp_port.valid && run_ff, (rsp_port.right_bound == prev_rb_ff) && (rsp_port.interval_length < prev_len_ff), "run words out of order")
   `LCP_ASSERT_IMPLY(a_bounds, clock, reset, rsp_port.valid, (rsp_port.left_bound <= rsp_port.right_bound) && (rsp_port.interval_length != '0), "bad interval word")

endmodule

bind lcp_interval_enumerator lcp_checker u_lcp_checker (
   .clock    (clock),
   .reset    (reset),
   .rsp_port (rsp_port)
);

@@ test/tb_lcp_interval_enumerator.sv @@
`timescale 1ns / 1ps
// ============================================================================
// LCP interval enumerator testbench
// Drives LCP words over the request channel and checks every interval word
// against the in-bench stack predictor, or typed rows' own words. A short
// directed table comes first, then runs of random LCP values, a full-depth
// stack drained under a long output stall, overflow, and a quiet tail.
// ============================================================================
module tb_lcp_interval_enumerator;
   import lcp_pkg::*;

   typedef struct packed {
      logic [15:0] length;
      logic [15:0] left_bound;
      logic [15:0] right_bound;
      logic        last_of_run;
      logic        overflow;
   } interval_word_type;

   typedef struct packed {
      logic [15:0]       value;
      logic              eoa;
      logic              typed;
      logic [6:0]        n_want;
      interval_word_type want;
   } stim_row_type;

   localparam int unsigned RSP_HOLD_CYCLES = 600;

   logic clock;
   logic reset;

   lcp_req_if req_if ();
   lcp_rsp_if rsp_if ();

   lcp_interval_enumerator u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if)
   );

   // predictor state
   logic [15:0]      open_len  [STACK_DEPTH];
   logic [15:0]      open_left [STACK_DEPTH];
   int unsigned      open_top;
   logic [POS_W-1:0] next_index;
   logic             stack_overflowed;

   interval_word_type pending_intervals [$];
   int unsigned       mismatches;
   logic              src_idle_en;
   logic              snk_idle_en;
   logic              rsp_hold_req;

   stim_row_type directed_rows [20] = '{
      '{16'h0000, 1'b0, 1'b1, 7'd0, '0},
      '{16'hFFFF, 1'b0, 1'b1, 7'd0, '0},
      '{16'h0000, 1'b0, 1'b1, 7'd1, '{16'hFFFF, 16'd1, 16'd2, 1'b1, 1'b0}},
      '{16'd3,    1'b0, 1'b0, 7'd0, '0},
      '{16'd5,    1'b0, 1'b0, 7'd0, '0},
      '{16'd5,    1'b0, 1'b0, 7'd0, '0},
      '{16'd4,    1'b0, 1'b0, 7'd0, '0},
      '{16'd1,    1'b0, 1'b0, 7'd0, '0},
      '{16'hAAAA, 1'b0, 1'b0, 7'd0, '0},
      '{16'h5555, 1'b0, 1'b0, 7'd0, '0},
      '{16'hFFFF, 1'b1, 1'b0, 7'd0, '0},
      '{16'h0000, 1'b1, 1'b1, 7'd0, '0},
      '{16'd1,    1'b0, 1'b0, 7'd0, '0},
      '{16'h1234, 1'b1, 1'b1, 7'd1, '{16'd1, 16'd0, 16'd1, 1'b1, 1'b0}},
      '{16'd2,    1'b0, 1'b0, 7'd0, '0},
      '{16'd7,    1'b0, 1'b0, 7'd0, '0},
      '{16'd7,    1'b0, 1'b0, 7'd0, '0},
      '{16'd2,    1'b0, 1'b0, 7'd0, '0},
      '{16'd0,    1'b0, 1'b0, 7'd0, '0},
      '{16'hFFFF, 1'b1, 1'b0, 7'd0, '0}
   };

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // bottom-up traversal: close intervals above the new value, then open one
   function automatic void advance_traversal(input logic [15:0] raw, input logic eoa,
                                             output interval_word_type run [$]);
      logic [15:0]       v;
      logic [POS_W-1:0]  idx;
      logic [15:0]       lb;
      interval_word_type w;
      run = {};
      v   = eoa ? 16'd0 : raw;
      idx = next_index;
      lb  = 16'(idx - 1'b1);
      while (open_top > 0 && v < open_len[open_top]) begin
         w.length      = open_len[open_top];
         w.left_bound  = open_left[open_top];
         w.right_bound = 16'(idx - 1'b1);
         w.last_of_run = 1'b0;
         w.overflow    = 1'b0;
         run = {run, w};
         lb = open_left[open_top];
         open_top--;
      end
      if (eoa) begin
         open_top   = 0;
         next_index = 1;
      end else begin
         if (v > open_len[open_top]) begin
            if (open_top + 1 < STACK_DEPTH) begin
               open_top++;
               open_len[open_top]  = v;
               open_left[open_top] = lb;
            end else begin
               stack_overflowed = 1'b1;
            end
         end
         if (next_index < MAX_POS) next_index++;
      end
      foreach (run[k]) begin
         run[k].last_of_run = (k == run.size() - 1);
         run[k].overflow    = stack_overflowed;
      end
   endfunction

   task automatic note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t mismatch: %s", $time, msg);
   endtask

   // entered and left at a falling edge
   task automatic send_word(input stim_row_type row);
      interval_word_type run [$];
      if (src_idle_en && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.lcp_value    <= row.value;
      req_if.end_of_array <= row.eoa;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      advance_traversal(row.value, row.eoa, run);
      if (row.typed) begin
         if (row.n_want != 0) pending_intervals = {pending_intervals, row.want};
      end else begin
         foreach (run[k]) pending_intervals = {pending_intervals, run[k]};
      end
      @(negedge clock);
   endtask

   task automatic offer(input logic [15:0] v, input logic eoa);
      stim_row_type row;
      row       = '0;
      row.value = v;
      row.eoa   = eoa;
      send_word(row);
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      while (pending_intervals.size() != 0) @(negedge clock);
   endtask

   task automatic send_random_runs(input int unsigned target, input logic allow_idle);
      int unsigned sent;
      int unsigned run_len;
      int unsigned style;
      int unsigned ceiling;
      int unsigned i;
      logic [15:0] v;
      logic [15:0] walk;
      sent = 0;
      while (sent < target) begin
         run_len     = $urandom_range(1, 40);
         style       = $urandom_range(0, 9);
         ceiling     = $urandom_range(1, 12);
         walk        = 16'($urandom_range(0, 4));
         src_idle_en = allow_idle && ($urandom_range(0, 3) != 0);
         snk_idle_en = allow_idle && ($urandom_range(0, 3) != 0);
         for (i = 0; i < run_len; i++) begin
            if (style <= 5) begin
               v = 16'($urandom_range(0, ceiling));
            end else if (style <= 7) begin
               if ($urandom_range(0, 2) != 0) walk = walk + 16'($urandom_range(1, 3));
               else if (walk > 3) walk = walk - 16'($urandom_range(1, 3));
               else walk = 16'd0;
               v = walk;
            end else if (style == 8) begin
               v = 16'($urandom);
            end else begin
               case ($urandom_range(0, 4))
                  0: v = 16'h0000;
                  1: v = 16'hFFFF;
                  2: v = 16'hFFFE;
                  3: v = 16'h0001;
                  default: v = 16'($urandom);
               endcase
            end
            // stray end markers break a run in the middle
            if ($urandom_range(0, 14) == 0) offer(16'($urandom), 1'b1);
            else offer(v, 1'b0);
            sent++;
         end
         if ($urandom_range(0, 4) != 0) begin
            offer(16'($urandom), 1'b1);
            sent++;
         end
      end
   endtask

   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         int unsigned stall_left;
         @(negedge clock);
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(negedge clock);
            rsp_if.ready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else if (snk_idle_en && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 12) - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      interval_word_type want;
      string             bad;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (pending_intervals.size() == 0) begin
            note_mismatch($sformatf(
               "unexpected interval word len=%0d lb=%0d rb=%0d last=%0b ovf=%0b",
               rsp_if.interval_length, rsp_if.left_bound,
               rsp_if.right_bound, rsp_if.last_of_run, rsp_if.overflow));
         end else begin
            want = pending_intervals.pop_front();
            bad  = "";
            if (rsp_if.interval_length !== want.length)      bad = {bad, " length"};
            if (rsp_if.left_bound      !== want.left_bound)  bad = {bad, " left"};
            if (rsp_if.right_bound     !== want.right_bound) bad = {bad, " right"};
            if (rsp_if.last_of_run     !== want.last_of_run) bad = {bad, " last"};
            if (rsp_if.overflow        !== want.overflow)    bad = {bad, " overflow"};
            if (bad.len() != 0)
               note_mismatch($sformatf(
                  "interval word [%s ] expected %0d/%0d/%0d/%0b/%0b got %0d/%0d/%0d/%0b/%0b",
                  bad, want.length, want.left_bound, want.right_bound, want.last_of_run,
                  want.overflow, rsp_if.interval_length, rsp_if.left_bound,
                  rsp_if.right_bound, rsp_if.last_of_run, rsp_if.overflow));
         end
      end
   end

   initial begin
      int unsigned n;
      reset               = 1'b1;
      req_if.valid        = 1'b0;
      req_if.lcp_value    = 16'd0;
      req_if.end_of_array = 1'b0;
      src_idle_en         = 1'b0;
      snk_idle_en         = 1'b0;
      rsp_hold_req        = 1'b0;
      mismatches          = 0;
      open_len[0]         = 16'd0;
      open_left[0]        = 16'd0;
      open_top            = 0;
      next_index          = 1;
      stack_overflowed    = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      src_idle_en = 1'b1;
      snk_idle_en = 1'b1;
      foreach (directed_rows[r]) send_word(directed_rows[r]);

      send_random_runs(100, 1'b1);
      drain();

      // full stack closed at once while the output is held off
      src_idle_en  = 1'b0;
      snk_idle_en  = 1'b0;
      rsp_hold_req = 1'b1;
      for (n = 1; n < STACK_DEPTH; n++) offer(16'(n), 1'b0);
      offer(16'd0, 1'b0);
      offer(16'd0, 1'b1);
      offer(16'd3, 1'b0);
      offer(16'd1, 1'b0);
      offer(16'd0, 1'b1);
      drain();

      // one push past a full stack sets the sticky flag
      for (n = 1; n <= STACK_DEPTH; n++) offer(16'(n), 1'b0);
      offer(16'd0, 1'b0);
      offer(16'd0, 1'b1);

      send_random_runs(70, 1'b1);
      send_random_runs(40, 1'b0);
      drain();
      repeat (20) @(posedge clock);

      if (mismatches == 0 && pending_intervals.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
